### hdl/sbd_pkg.sv
// Shared types, constants and pixel helpers for the spectrum bin display pipeline.
// No dependencies; sbd_front, sbd_back and the top level import this package.
`default_nettype none

package sbd_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [9:0]  CHART_SCALE       = 10'd1000;
  localparam logic [5:0]  DIM_GAIN          = 6'd51;
  localparam logic [5:0]  MARKER_PERIOD_RST = 6'd30;
  localparam logic [15:0] PEAK_DECAY_RST    = 16'd63570;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PEAK_HOLD     = 2'd0,
    REG_TIME_GRID     = 2'd1,
    REG_MARKER_PERIOD = 2'd2,
    REG_PEAK_DECAY    = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic        peak_hold_enable;
    logic        time_grid_enable;
    logic [5:0]  marker_period;
    logic [15:0] peak_decay;
  } cfg_t;

  // One classified bin as it travels from the front to the back.
  typedef struct packed {
    logic [15:0] magnitude;
    logic [9:0]  chart;
    logic [15:0] top;
    logic        marker;
    logic        last;
    logic        fresh;   // first row since reset: stores hold nothing yet
  } item_t;

  // Scale each RGB565 channel by 51/256, truncating.
  function automatic logic [15:0] darken565(input logic [15:0] px);
    logic [10:0] r;
    logic [11:0] g;
    logic [10:0] b;
    r = 11'(px[15:11]) * 11'(DIM_GAIN);
    g = 12'(px[10:5])  * 12'(DIM_GAIN);
    b = 11'(px[4:0])   * 11'(DIM_GAIN);
    return {2'b00, r[10:8], 2'b00, g[11:8], 2'b00, b[10:8]};
  endfunction

endpackage

`default_nettype wire

### hdl/sbd_queue.sv
// Small FIFO between the front and back parts of the display pipeline.
// Depends on nothing but its parameters; sbd_pkg sets the depth used.
`default_nettype none

module sbd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign valid = (count != '0);
  assign rdata = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/sbd_front.sv
// Front part: takes bins, tracks row position and marker rows, computes
// chart value and colormap pixel. Depends on sbd_pkg.
`default_nettype none

module sbd_front
  import sbd_pkg::*;
#(
  parameter int BINS  = 256,
  parameter int POS_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             in_valid,
  input  logic [15:0]      magnitude,
  input  logic             q_full,
  output logic             push,
  output logic [POS_W-1:0] pos,
  output item_t            item
);

  logic [POS_W-1:0] bin_position;
  logic [5:0]       row_counter;
  logic             marker_row_flag;
  logic             first_row;

  logic [5:0]  row_counter_next;
  logic        marker_next;
  logic [6:0]  count_inc;
  logic        at_last;
  logic [25:0] chart_prod;
  logic [13:0] frac;
  logic [7:0]  up;
  logic [7:0]  down;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [15:0] pixel;

  function automatic logic [7:0] ramp8(input logic [14:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd255 + 23'd8192;
    return p[21:14];
  endfunction

  assign push    = in_valid && !q_full;
  assign pos     = bin_position;
  assign at_last = (bin_position == POS_W'(BINS - 1));

  // Row start: update the marker flag from the time grid registers.
  always_comb begin
    count_inc        = {1'b0, row_counter} + 7'd1;
    row_counter_next = row_counter;
    marker_next      = marker_row_flag;
    if (bin_position == '0) begin
      if (cfg.time_grid_enable) begin
        if (count_inc >= {1'b0, cfg.marker_period}) begin
          marker_next      = 1'b1;
          row_counter_next = '0;
        end else begin
          marker_next      = 1'b0;
          row_counter_next = count_inc[5:0];
        end
      end else begin
        marker_next      = 1'b0;
        row_counter_next = '0;
      end
    end
  end

  // Four-segment colormap, black-blue-cyan-yellow-red.
  always_comb begin
    frac = magnitude[13:0];
    up   = ramp8({1'b0, frac});
    down = ramp8(15'd16384 - {1'b0, frac});
    case (magnitude[15:14])
      2'd0: begin
        red = 8'd0;   green = 8'd0;   blue = up;
      end
      2'd1: begin
        red = 8'd0;   green = up;     blue = 8'd255;
      end
      2'd2: begin
        red = up;     green = 8'd255; blue = down;
      end
      default: begin
        red = 8'd255; green = down;   blue = 8'd0;
      end
    endcase
    pixel = {red[7:3], green[7:2], blue[7:3]};
  end

  assign chart_prod = 26'(magnitude) * 26'(CHART_SCALE);

  always_comb begin
    item.magnitude = magnitude;
    item.chart     = chart_prod[25:16];
    item.top       = marker_next ? darken565(pixel) : pixel;
    item.marker    = marker_next;
    item.last      = at_last;
    item.fresh     = first_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_position    <= '0;
      row_counter     <= '0;
      marker_row_flag <= 1'b0;
      first_row       <= 1'b1;
    end else if (push) begin
      bin_position    <= at_last ? '0 : bin_position + 1'b1;
      row_counter     <= row_counter_next;
      marker_row_flag <= marker_next;
      if (at_last) begin
        first_row <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/sbd_back.sv
// Back part: per-bin peak hold and previous-row pixel stores, output register.
// Depends on sbd_pkg.
`default_nettype none

module sbd_back
  import sbd_pkg::*;
#(
  parameter int BINS  = 256,
  parameter int POS_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             q_valid,
  input  logic [POS_W-1:0] q_pos,
  input  item_t            q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [9:0]       chart_value,
  output logic [9:0]       peak_value,
  output logic [15:0]      top_pixel,
  output logic [15:0]      below_pixel,
  output logic             below_rewrite,
  output logic             last_in_row
);

  logic [15:0] peak_mem [BINS];
  logic [15:0] prev_mem [BINS];

  logic             adv;
  logic [15:0]      peak_rd;
  logic [15:0]      prev_rd;

  logic             s1_valid;
  logic [POS_W-1:0] s1_pos;
  item_t            s1_item;

  logic             s2_valid;
  logic [POS_W-1:0] s2_pos;
  item_t            s2_item;
  logic [15:0]      s2_decayed;
  logic [15:0]      s2_below;

  logic [15:0] peak_cur;
  logic [15:0] prev_cur;
  logic [31:0] decay_prod;
  logic [15:0] held;
  logic [25:0] peak_prod;

  // Advance every stage together whenever the output register is free.
  assign adv   = !out_valid || !out_stall;
  assign q_pop = adv && q_valid;

  // Entries not yet written in the first row read as zero.
  assign peak_cur   = s1_item.fresh ? '0 : peak_rd;
  assign prev_cur   = s1_item.fresh ? '0 : prev_rd;
  assign decay_prod = 32'(peak_cur) * 32'(cfg.peak_decay);

  always_comb begin
    if (!cfg.peak_hold_enable) begin
      held = '0;
    end else if (s2_item.magnitude > s2_decayed) begin
      held = s2_item.magnitude;
    end else begin
      held = s2_decayed;
    end
  end

  assign peak_prod = 26'(held) * 26'(CHART_SCALE);

  always_ff @(posedge clk) begin
    if (adv) begin
      peak_rd <= peak_mem[q_pos];
    end
    if (adv && s2_valid) begin
      peak_mem[s2_pos] <= held;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prev_rd <= prev_mem[q_pos];
    end
    if (adv && s2_valid) begin
      prev_mem[s2_pos] <= s2_item.top;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= q_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pos        <= q_pos;
      s1_item       <= q_item;
      s2_pos        <= s1_pos;
      s2_item       <= s1_item;
      s2_decayed    <= decay_prod[31:16];
      s2_below      <= s1_item.marker ? darken565(prev_cur) : '0;
      chart_value   <= s2_item.chart;
      peak_value    <= peak_prod[25:16];
      top_pixel     <= s2_item.top;
      below_pixel   <= s2_below;
      below_rewrite <= s2_item.marker;
      last_in_row   <= s2_item.last;
    end
  end

endmodule

`default_nettype wire

### hdl/spectrum_bin_display_pipeline_core.sv
// Top level of the spectrum bin display pipeline: config registers, front,
// queue and back. Depends on sbd_pkg, sbd_front, sbd_queue and sbd_back.
//
//   Channel  Direction  Handshake                  Payload
//   input    in         in_valid / in_stall        magnitude
//   output   out        out_valid / out_stall      chart_value, peak_value, top_pixel,
//                                                  below_pixel, below_rewrite, last_in_row
//   config   in         cfg_we (no handshake back) cfg_index, cfg_data
//
// Rate: one bin per cycle sustained while out_stall is low; the per-bin
// read-modify-write of the peak and previous-row memories is pipelined over two back
// stages, s1 and s2, after the queue and before the output register.
// Reset: rst is synchronous; it empties the queue and pipeline and restores
// the register defaults. The stores need no clearing pass: during the first row
// after reset each bin reads as zero until its entry has been written.
// Stalls: in_stall rises only when the four-entry queue is full; out_stall
// freezes the back stages while the front keeps filling the queue.
`default_nettype none

module spectrum_bin_display_pipeline_core
  import sbd_pkg::*;
#(
  parameter int BINS = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [15:0]            magnitude,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [9:0]             chart_value,
  output logic [9:0]             peak_value,
  output logic [15:0]            top_pixel,
  output logic [15:0]            below_pixel,
  output logic                   below_rewrite,
  output logic                   last_in_row
);

  localparam int POS_W = $clog2(BINS);
  localparam int Q_W   = POS_W + $bits(item_t);

  cfg_t cfg;

  logic             fe_push;
  logic [POS_W-1:0] fe_pos;
  item_t            fe_item;

  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  logic [Q_W-1:0]   q_rdata;
  logic [POS_W-1:0] q_pos;
  item_t            q_item;

  // Configuration writes; indexes outside the map are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.peak_hold_enable <= 1'b0;
      cfg.time_grid_enable <= 1'b0;
      cfg.marker_period    <= MARKER_PERIOD_RST;
      cfg.peak_decay       <= PEAK_DECAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        REG_PEAK_HOLD:     cfg.peak_hold_enable <= cfg_data[0];
        REG_TIME_GRID:     cfg.time_grid_enable <= cfg_data[0];
        REG_MARKER_PERIOD: cfg.marker_period    <= cfg_data[5:0];
        REG_PEAK_DECAY:    cfg.peak_decay       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Stall the input only on a full queue.
  assign in_stall = q_full;

  sbd_front #(
    .BINS  (BINS),
    .POS_W (POS_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .magnitude (magnitude),
    .q_full    (q_full),
    .push      (fe_push),
    .pos       (fe_pos),
    .item      (fe_item)
  );

  sbd_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (fe_push),
    .wdata ({fe_pos, fe_item}),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  assign q_pos  = q_rdata[Q_W-1 -: POS_W];
  assign q_item = item_t'(q_rdata[$bits(item_t)-1:0]);

  sbd_back #(
    .BINS  (BINS),
    .POS_W (POS_W)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_pos         (q_pos),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .chart_value   (chart_value),
    .peak_value    (peak_value),
    .top_pixel     (top_pixel),
    .below_pixel   (below_pixel),
    .below_rewrite (below_rewrite),
    .last_in_row   (last_in_row)
  );

`ifndef ASSERT_OFF
  // The pipeline comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set right after reset");

  // Outside marker rows the previous-row pixel is reported as black.
  a_below_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !below_rewrite) |-> (below_pixel == '0))
    else $error("below_pixel nonzero without rewrite");

  // The bin after the last of a row starts the next row.
  a_row_wrap: assert property (@(posedge clk) disable iff (rst)
    (fe_push && fe_item.last) |=> (fe_pos == '0))
    else $error("bin position did not wrap after last bin");
`endif

endmodule

`default_nettype wire
